// ----- hdl/rmj_pkg.sv -----
// rmj_pkg: constants, shared widths and the output saturation function
// for the radar measurement Jacobian pipeline.
// No dependencies.
package rmj_pkg;

    // Quotient bits kept by each divider (enough to detect 32-bit overflow)
    localparam int QUO_W = 33;

    // One root bit per square root stage, 64-bit radicand
    localparam int SQRT_STAGES = 32;

    localparam logic [62:0] MIN_RANGE_SQ_RESET = 63'd43;

    // Flag and sign bits that travel beside the dividers
    typedef struct packed {
        logic calc;
        logic sx;
        logic sy;
        logic ssp;
    } sign_t;

    // Saturate a sign-magnitude quotient to a 32-bit two's complement entry
    function automatic logic [31:0] sat32(input logic neg, input logic ovf,
                                          input logic [QUO_W-1:0] q);
        logic [QUO_W-1:0] lim;
        logic [31:0]      mag;
        lim = neg ? QUO_W'(32'h8000_0000) : QUO_W'(32'h7FFF_FFFF);
        mag = (ovf || (q > lim)) ? lim[31:0] : q[31:0];
        return neg ? (~mag + 32'd1) : mag;
    endfunction

endpackage

// ----- hdl/rmj_delay.sv -----
// rmj_delay: stallable shift line that carries side data beside a pipeline.
// Depends on nothing.
module rmj_delay #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    // Shift one place per advancing cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

// ----- hdl/rmj_sqrt.sv -----
// rmj_sqrt: pipelined integer square root of a 64-bit value, one root bit
// per stage. Depends on rmj_pkg.
module rmj_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);

    localparam int N = rmj_pkg::SQRT_STAGES;

    logic [33:0] rem_reg  [N];
    logic [31:0] root_reg [N];
    logic [63:0] rad_reg  [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [35:0] cand;
        logic [35:0] trial;
        logic        fits;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rad_in  = rad_reg[j-1];
        end

        // Bring down two radicand bits, try root*4+1
        assign cand  = {rem_in, rad_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign fits  = (cand >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= fits ? 34'(cand - trial) : cand[33:0];
                root_reg[j] <= {root_in[30:0], fits};
                rad_reg[j]  <= {rad_in[61:0], 2'b00};
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

// ----- hdl/rmj_div.sv -----
// rmj_div: pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients of 2^QUO_W and above. Depends on rmj_pkg.
module rmj_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [NW-1:0]            num,
    input  logic [DW-1:0]            den,
    output logic [rmj_pkg::QUO_W-1:0] quo,
    output logic                     ovf
);

    localparam int QW = rmj_pkg::QUO_W;
    localparam int WW = NW + DW;

    logic [DW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic          ovf_reg [QW+1];

    logic [WW-1:0] num_hi;

    // Entry stage: overflow test and the partial remainder above the quotient
    assign num_hi = WW'(num) >> QW;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_hi[DW-1:0];
            den_reg[0] <= den;
            low_reg[0] <= num[QW-1:0];
            quo_reg[0] <= '0;
            ovf_reg[0] <= (num_hi >= WW'(den));
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] trial;
        logic        ge;

        // Shift in the next numerator bit and subtract where it fits
        assign trial = {rem_reg[k-1], low_reg[k-1][QW-1]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? DW'(trial - {1'b0, den_reg[k-1]}) : trial[DW-1:0];
                den_reg[k] <= den_reg[k-1];
                low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

// ----- hdl/radar_measurement_jacobian_top.sv -----
// radar_measurement_jacobian_top: radar range/bearing/range-rate Jacobian
// from a (px, py, vx, vy) state. Depends on rmj_pkg, rmj_delay, rmj_sqrt, rmj_div.

// One state item enters per clock while the pipeline is not held. Stages a,
// b and c form magnitudes, squares and sums, followed by the square root (one
// root bit per stage), stages e and f for the wide products of the range-rate
// terms, the six dividers (one quotient bit per stage), and then
// saturation into the output register. The whole pipeline advances together;
// it holds only while the output register holds a result that m_ready has not
// taken, and s_ready is low exactly then. min_range_squared is written through
// cfg_wr_en/cfg_wr_data and is compared with px^2+py^2 in 2*FRAC_BITS format;
// below it, or at zero range, the flag is clear and all entries are zero.
module radar_measurement_jacobian_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [62:0]        cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_calculable,
    output logic signed [31:0] m_range_dx,
    output logic signed [31:0] m_range_dy,
    output logic signed [31:0] m_bearing_dx,
    output logic signed [31:0] m_bearing_dy,
    output logic signed [31:0] m_rate_dx,
    output logic signed [31:0] m_rate_dy
);

    localparam int QW   = rmj_pkg::QUO_W;
    localparam int SQN  = rmj_pkg::SQRT_STAGES;
    localparam int LAT  = 3 + SQN + 2 + (QW + 1) + 1;
    localparam int NR_W = 32 + FRAC_BITS;
    localparam int NB_W = 32 + 2 * FRAC_BITS;
    localparam int NT_W = 96 + FRAC_BITS;

    typedef struct packed {
        logic        calc;
        logic        sx;
        logic        sy;
        logic        ssp;
        logic [31:0] mx;
        logic [31:0] my;
        logic [63:0] p;
        logic [63:0] msp;
    } mid_t;

    logic [62:0]    thr_reg;
    logic [LAT-1:0] vld_reg;
    logic           en;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= rmj_pkg::MIN_RANGE_SQ_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Pipeline control: valid bits shift with the data
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Stage a: sign and magnitude
    logic        a_sx_reg, a_sy_reg, a_svx_reg, a_svy_reg;
    logic [31:0] a_mx_reg, a_my_reg, a_mvx_reg, a_mvy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sx_reg  <= s_pos_x[31];
            a_sy_reg  <= s_pos_y[31];
            a_svx_reg <= s_vel_x[31];
            a_svy_reg <= s_vel_y[31];
            a_mx_reg  <= s_pos_x[31] ? (32'd0 - $unsigned(s_pos_x)) : $unsigned(s_pos_x);
            a_my_reg  <= s_pos_y[31] ? (32'd0 - $unsigned(s_pos_y)) : $unsigned(s_pos_y);
            a_mvx_reg <= s_vel_x[31] ? (32'd0 - $unsigned(s_vel_x)) : $unsigned(s_vel_x);
            a_mvy_reg <= s_vel_y[31] ? (32'd0 - $unsigned(s_vel_y)) : $unsigned(s_vel_y);
        end
    end

    // Stage b: squares and cross products
    logic        b_sx_reg, b_sy_reg, b_sa_reg, b_sb_reg;
    logic [31:0] b_mx_reg, b_my_reg;
    logic [63:0] b_px2_reg, b_py2_reg, b_ma_reg, b_mb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sx_reg  <= a_sx_reg;
            b_sy_reg  <= a_sy_reg;
            b_sa_reg  <= a_svx_reg ^ a_sy_reg;
            b_sb_reg  <= ~(a_svy_reg ^ a_sx_reg);
            b_mx_reg  <= a_mx_reg;
            b_my_reg  <= a_my_reg;
            b_px2_reg <= 64'(a_mx_reg) * 64'(a_mx_reg);
            b_py2_reg <= 64'(a_my_reg) * 64'(a_my_reg);
            b_ma_reg  <= 64'(a_mvx_reg) * 64'(a_my_reg);
            b_mb_reg  <= 64'(a_mvy_reg) * 64'(a_mx_reg);
        end
    end

    // Stage c: squared range and the signed cross term vx*py - vy*px
    logic        c_sx_reg, c_sy_reg, c_ssp_reg;
    logic [31:0] c_mx_reg, c_my_reg;
    logic [63:0] c_p_reg, c_msp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c_sx_reg <= b_sx_reg;
            c_sy_reg <= b_sy_reg;
            c_mx_reg <= b_mx_reg;
            c_my_reg <= b_my_reg;
            c_p_reg  <= b_px2_reg + b_py2_reg;
            if (b_sa_reg == b_sb_reg) begin
                c_msp_reg <= b_ma_reg + b_mb_reg;
                c_ssp_reg <= b_sa_reg;
            end else if (b_ma_reg >= b_mb_reg) begin
                c_msp_reg <= b_ma_reg - b_mb_reg;
                c_ssp_reg <= b_sa_reg;
            end else begin
                c_msp_reg <= b_mb_reg - b_ma_reg;
                c_ssp_reg <= b_sb_reg;
            end
        end
    end

    // Square root, with the rest of the item riding alongside
    mid_t        c_mid;
    mid_t        d_mid;
    logic [31:0] d_root;

    assign c_mid.calc = (c_p_reg != 64'd0) && (c_p_reg >= {1'b0, thr_reg});
    assign c_mid.sx   = c_sx_reg;
    assign c_mid.sy   = c_sy_reg;
    assign c_mid.ssp  = c_ssp_reg;
    assign c_mid.mx   = c_mx_reg;
    assign c_mid.my   = c_my_reg;
    assign c_mid.p    = c_p_reg;
    assign c_mid.msp  = c_msp_reg;

    rmj_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (c_p_reg),
        .root (d_root)
    );

    rmj_delay #(.W($bits(mid_t)), .N(SQN)) u_mid_dly (
        .aclk (aclk),
        .en   (en),
        .din  (c_mid),
        .dout (d_mid)
    );

    // Stage e: 32x32 partial products of the range-rate terms
    rmj_pkg::sign_t e_sgn_reg;
    logic [31:0]    e_mx_reg, e_my_reg, e_r_reg;
    logic [63:0]    e_p_reg;
    logic [63:0]    e_ylo_reg, e_yhi_reg, e_xlo_reg, e_xhi_reg, e_plo_reg, e_phi_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e_sgn_reg <= '{calc: d_mid.calc, sx: d_mid.sx, sy: d_mid.sy, ssp: d_mid.ssp};
            e_mx_reg  <= d_mid.mx;
            e_my_reg  <= d_mid.my;
            e_r_reg   <= d_root;
            e_p_reg   <= d_mid.p;
            e_ylo_reg <= 64'(d_mid.my) * 64'(d_mid.msp[31:0]);
            e_yhi_reg <= 64'(d_mid.my) * 64'(d_mid.msp[63:32]);
            e_xlo_reg <= 64'(d_mid.mx) * 64'(d_mid.msp[31:0]);
            e_xhi_reg <= 64'(d_mid.mx) * 64'(d_mid.msp[63:32]);
            e_plo_reg <= 64'(d_mid.p[31:0]) * 64'(d_root);
            e_phi_reg <= 64'(d_mid.p[63:32]) * 64'(d_root);
        end
    end

    // Stage f: combine partial products into 96-bit terms
    rmj_pkg::sign_t f_sgn_reg;
    logic [31:0]    f_mx_reg, f_my_reg, f_r_reg;
    logic [63:0]    f_p_reg;
    logic [95:0]    f_numy_reg, f_numx_reg, f_den3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f_sgn_reg  <= e_sgn_reg;
            f_mx_reg   <= e_mx_reg;
            f_my_reg   <= e_my_reg;
            f_r_reg    <= e_r_reg;
            f_p_reg    <= e_p_reg;
            f_numy_reg <= 96'(e_ylo_reg) + {e_yhi_reg, 32'd0};
            f_numx_reg <= 96'(e_xlo_reg) + {e_xhi_reg, 32'd0};
            f_den3_reg <= 96'(e_plo_reg) + {e_phi_reg, 32'd0};
        end
    end

    // Six dividers in parallel
    logic [QW-1:0]  q_rdx, q_rdy, q_bdx, q_bdy, q_tdx, q_tdy;
    logic           o_rdx, o_rdy, o_bdx, o_bdy, o_tdx, o_tdy;
    rmj_pkg::sign_t g_sgn;

    rmj_div #(.NW(NR_W), .DW(32)) u_div_rdx (
        .aclk (aclk), .en (en),
        .num  (NR_W'(f_mx_reg) << FRAC_BITS), .den (f_r_reg),
        .quo  (q_rdx), .ovf (o_rdx)
    );

    rmj_div #(.NW(NR_W), .DW(32)) u_div_rdy (
        .aclk (aclk), .en (en),
        .num  (NR_W'(f_my_reg) << FRAC_BITS), .den (f_r_reg),
        .quo  (q_rdy), .ovf (o_rdy)
    );

    rmj_div #(.NW(NB_W), .DW(64)) u_div_bdx (
        .aclk (aclk), .en (en),
        .num  (NB_W'(f_my_reg) << (2 * FRAC_BITS)), .den (f_p_reg),
        .quo  (q_bdx), .ovf (o_bdx)
    );

    rmj_div #(.NW(NB_W), .DW(64)) u_div_bdy (
        .aclk (aclk), .en (en),
        .num  (NB_W'(f_mx_reg) << (2 * FRAC_BITS)), .den (f_p_reg),
        .quo  (q_bdy), .ovf (o_bdy)
    );

    rmj_div #(.NW(NT_W), .DW(96)) u_div_tdx (
        .aclk (aclk), .en (en),
        .num  (NT_W'(f_numy_reg) << FRAC_BITS), .den (f_den3_reg),
        .quo  (q_tdx), .ovf (o_tdx)
    );

    rmj_div #(.NW(NT_W), .DW(96)) u_div_tdy (
        .aclk (aclk), .en (en),
        .num  (NT_W'(f_numx_reg) << FRAC_BITS), .den (f_den3_reg),
        .quo  (q_tdy), .ovf (o_tdy)
    );

    rmj_delay #(.W($bits(rmj_pkg::sign_t)), .N(QW + 1)) u_sgn_dly (
        .aclk (aclk),
        .en   (en),
        .din  (f_sgn_reg),
        .dout (g_sgn)
    );

    // Output register: saturate, apply signs, zero when not calculable
    logic        calc_reg;
    logic [31:0] rdx_reg, rdy_reg, bdx_reg, bdy_reg, tdx_reg, tdy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            calc_reg <= g_sgn.calc;
            rdx_reg  <= g_sgn.calc ? rmj_pkg::sat32(g_sgn.sx, o_rdx, q_rdx) : 32'd0;
            rdy_reg  <= g_sgn.calc ? rmj_pkg::sat32(g_sgn.sy, o_rdy, q_rdy) : 32'd0;
            bdx_reg  <= g_sgn.calc ? rmj_pkg::sat32(~g_sgn.sy, o_bdx, q_bdx) : 32'd0;
            bdy_reg  <= g_sgn.calc ? rmj_pkg::sat32(g_sgn.sx, o_bdy, q_bdy) : 32'd0;
            tdx_reg  <= g_sgn.calc ?
                        rmj_pkg::sat32(g_sgn.sy ^ g_sgn.ssp, o_tdx, q_tdx) : 32'd0;
            tdy_reg  <= g_sgn.calc ?
                        rmj_pkg::sat32(~(g_sgn.sx ^ g_sgn.ssp), o_tdy, q_tdy) : 32'd0;
        end
    end

    assign m_calculable = calc_reg;
    assign m_range_dx   = $signed(rdx_reg);
    assign m_range_dy   = $signed(rdy_reg);
    assign m_bearing_dx = $signed(bdx_reg);
    assign m_bearing_dy = $signed(bdy_reg);
    assign m_rate_dx    = $signed(tdx_reg);
    assign m_rate_dy    = $signed(tdy_reg);

endmodule

// ----- hdl/rmj_checker.sv -----
// rmj_checker: port-level assertions for radar_measurement_jacobian_top,
// attached by the bind statement at the end. Depends on the top level only.
module rmj_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_calculable,
    input logic signed [31:0] m_range_dx,
    input logic signed [31:0] m_range_dy,
    input logic signed [31:0] m_bearing_dx,
    input logic signed [31:0] m_bearing_dy,
    input logic signed [31:0] m_rate_dx,
    input logic signed [31:0] m_rate_dy
);

    // A waiting result item holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_dx) && $stable(m_rate_dy))
        else $error("result item changed while stalled");

    // No result item right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Not calculable means all entries are zero
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_calculable |->
            m_range_dx == 0 && m_range_dy == 0 && m_bearing_dx == 0 &&
            m_bearing_dy == 0 && m_rate_dx == 0 && m_rate_dy == 0)
        else $error("entries not zero for a non-calculable item");

    // px/range and px/range^2 share the sign of px
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_calculable |->
            m_range_dx == 0 || m_bearing_dy == 0 || m_range_dx[31] == m_bearing_dy[31])
        else $error("sign mismatch between range and bearing entries");

endmodule

bind radar_measurement_jacobian_top rmj_checker u_rmj_checker (.*);

// ----- tb/tb.sv -----
// tb: self-checking testbench for radar_measurement_jacobian_top.
// Drives state items through the input channel and compares each Jacobian
// result with a bit-exact predictor; depends on rmj_pkg and the RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = 16;
    localparam int LATENCY  = 72;
    localparam int DRAIN    = LATENCY + 20;
    localparam int MAX_CYC  = 400000;
    localparam int RAND_PER = 300;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } state_item_t;

    typedef struct {
        logic        calc;
        logic [31:0] rdx;
        logic [31:0] rdy;
        logic [31:0] bdx;
        logic [31:0] bdy;
        logic [31:0] vdx;
        logic [31:0] vdy;
    } jacobian_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [62:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    logic signed [31:0] s_pos_x, s_pos_y, s_vel_x, s_vel_y;
    logic m_valid;
    logic m_ready;
    logic m_calculable;
    logic signed [31:0] m_range_dx, m_range_dy, m_bearing_dx, m_bearing_dy;
    logic signed [31:0] m_rate_dx, m_rate_dy;

    state_item_t pending_q[$];
    jacobian_t   jacobian_q[$];
    logic [62:0] threshold;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors = 0;
    int          cycles = 0;

    radar_measurement_jacobian_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_vel_x     (s_vel_x),
        .s_vel_y     (s_vel_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_calculable(m_calculable),
        .m_range_dx  (m_range_dx),
        .m_range_dy  (m_range_dy),
        .m_bearing_dx(m_bearing_dx),
        .m_bearing_dy(m_bearing_dy),
        .m_rate_dx   (m_rate_dx),
        .m_rate_dy   (m_rate_dy)
    );

    // Clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Floor square root of a 64-bit value
    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= v)
                root = trial;
        end
        return root;
    endfunction

    // Saturate a sign-magnitude quotient to a 32-bit entry
    function automatic logic [31:0] clamp_entry(input logic neg, input logic [127:0] q);
        logic [127:0] lim;
        logic [31:0]  mag;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        mag = (q > lim) ? lim[31:0] : q[31:0];
        return neg ? (32'd0 - mag) : mag;
    endfunction

    function automatic logic [32:0] magnitude(input logic signed [31:0] v);
        return v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    endfunction

    // Jacobian entries for one state item under the given threshold
    function automatic jacobian_t predict_jacobian(input state_item_t it,
                                                   input logic [62:0] thr);
        jacobian_t          j;
        logic [32:0]        mx, my;
        logic [63:0]        p;
        logic [31:0]        r;
        logic signed [65:0] spv;
        logic [65:0]        msp;
        logic               ssp;
        logic [127:0]       den3;
        j = '{default: '0};
        mx = magnitude(it.px);
        my = magnitude(it.py);
        p = 64'(mx) * 64'(mx) + 64'(my) * 64'(my);
        if (p == 0 || p < 64'(thr))
            return j;
        r = floor_sqrt(p);
        spv = 66'(it.vx) * 66'(it.py) - 66'(it.vy) * 66'(it.px);
        ssp = spv < 0;
        msp = ssp ? 66'(-spv) : 66'(spv);
        den3 = 128'(p) * 128'(r);
        j.calc = 1'b1;
        j.rdx = clamp_entry(it.px[31], (128'(mx) << FRAC) / 128'(r));
        j.rdy = clamp_entry(it.py[31], (128'(my) << FRAC) / 128'(r));
        j.bdx = clamp_entry(!it.py[31], (128'(my) << (2 * FRAC)) / 128'(p));
        j.bdy = clamp_entry(it.px[31], (128'(mx) << (2 * FRAC)) / 128'(p));
        j.vdx = clamp_entry(it.py[31] != ssp, ((128'(my) << FRAC) * 128'(msp)) / den3);
        j.vdy = clamp_entry(!(it.px[31] != ssp), ((128'(mx) << FRAC) * 128'(msp)) / den3);
        return j;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(60000000)) - 30000000);
        endcase
    endfunction

    function automatic state_item_t make_item(input logic [31:0] px, input logic [31:0] py,
                                              input logic [31:0] vx, input logic [31:0] vy);
        state_item_t it;
        it.px = px;
        it.py = py;
        it.vx = vx;
        it.vy = vy;
        return it;
    endfunction

    // Driver: accepted items are predicted, then the next item is offered
    always @(posedge aclk) begin
        state_item_t nxt;
        logic        busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_pos_x <= '0;
            s_pos_y <= '0;
            s_vel_x <= '0;
            s_vel_y <= '0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                jacobian_q.push_back(predict_jacobian(make_item(s_pos_x, s_pos_y,
                                                                s_vel_x, s_vel_y), threshold));
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_q.pop_front();
                    s_pos_x <= nxt.px;
                    s_pos_y <= nxt.py;
                    s_vel_x <= nxt.vx;
                    s_vel_y <= nxt.vy;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        jacobian_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (jacobian_q.size() == 0) begin
                    $display("%0t: result with no expectation", $time);
                    errors++;
                end else begin
                    e = jacobian_q.pop_front();
                    if (m_calculable !== e.calc) begin
                        $display("%0t: calculable exp %0d got %0d", $time, e.calc, m_calculable);
                        errors++;
                    end
                    if (m_range_dx !== e.rdx) begin
                        $display("%0t: range_dx exp %h got %h", $time, e.rdx, m_range_dx);
                        errors++;
                    end
                    if (m_range_dy !== e.rdy) begin
                        $display("%0t: range_dy exp %h got %h", $time, e.rdy, m_range_dy);
                        errors++;
                    end
                    if (m_bearing_dx !== e.bdx) begin
                        $display("%0t: bearing_dx exp %h got %h", $time, e.bdx, m_bearing_dx);
                        errors++;
                    end
                    if (m_bearing_dy !== e.bdy) begin
                        $display("%0t: bearing_dy exp %h got %h", $time, e.bdy, m_bearing_dy);
                        errors++;
                    end
                    if (m_rate_dx !== e.vdx) begin
                        $display("%0t: rate_dx exp %h got %h", $time, e.vdx, m_rate_dx);
                        errors++;
                    end
                    if (m_rate_dy !== e.vdy) begin
                        $display("%0t: rate_dy exp %h got %h", $time, e.vdy, m_rate_dy);
                        errors++;
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Timeout
    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus: one threshold setting per phase, written while idle
    initial begin
        logic [62:0] settings[6];
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        aresetn = 1'b0;
        threshold = rmj_pkg::MIN_RANGE_SQ_RESET;
        send_idle_pct = 18;
        recv_idle_pct = 51;
        settings[0] = rmj_pkg::MIN_RANGE_SQ_RESET;
        settings[1] = 63'd0;
        settings[2] = 63'h7FFF_FFFF_FFFF_FFFF;
        settings[3] = 63'(64'd1 << 40);
        settings[4] = 63'({$urandom, $urandom} >> 30);
        settings[5] = 63'd1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 51;
                recv_idle_pct = 18;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // phase 0 keeps the reset value to check it
            if (ph > 0) begin
                @(posedge aclk);
                cfg_wr_en <= 1'b1;
                cfg_wr_data <= settings[ph];
                @(posedge aclk);
                cfg_wr_en <= 1'b0;
                threshold = settings[ph];
            end
            // directed corners: extremes, tiny ranges near threshold, zero range
            if (ph <= 1) begin
                pending_q.push_back(make_item(32'h8000_0000, 32'h8000_0000,
                                              32'h8000_0000, 32'h8000_0000));
                pending_q.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                              32'h7FFF_FFFF, 32'h7FFF_FFFF));
                pending_q.push_back(make_item(32'h8000_0000, 32'h7FFF_FFFF,
                                              32'h7FFF_FFFF, 32'h8000_0000));
                pending_q.push_back(make_item(0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
                pending_q.push_back(make_item(1, 0, 32'h7FFF_FFFF, 32'h8000_0000));
                pending_q.push_back(make_item(0, -1, 32'h8000_0000, 32'h7FFF_FFFF));
                pending_q.push_back(make_item(6, 3, 1, -1));
                pending_q.push_back(make_item(6, 2, 1, -1));
                pending_q.push_back(make_item(-7, 0, 5, 5));
                pending_q.push_back(make_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0));
                pending_q.push_back(make_item(-65536, 65536, 0, 32'hFFFF_0000));
                pending_q.push_back(make_item(32'h8000_0000, 0, 0, 0));
            end
            for (int i = 0; i < RAND_PER; i++)
                pending_q.push_back(make_item(rand_coord(), rand_coord(),
                                              rand_coord(), rand_coord()));
            while (pending_q.size() > 0 || s_valid || jacobian_q.size() > 0)
                @(posedge aclk);
            repeat (DRAIN) @(posedge aclk);
        end

        if (errors == 0 && jacobian_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
